/* hdl/bcgd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bcgd_pkg;

  // Widths fixed by the field definitions.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GESTURE_W  = 2;
  localparam int EDGE_CNT_W = 2;

  // Edge spacing counter saturates here; an edge is accepted once it is reached.
  localparam logic [EDGE_CNT_W-1:0] EDGE_SPACED = 2'd2;

  // Register reset values.
  localparam logic                  KEY_DOWN_LEVEL_RST = 1'b0;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST     = 16'd100;
  localparam logic [CFG_DATA_W-1:0] DOUBLE_CLICK_RST   = 16'd30;

  typedef enum logic [GESTURE_W-1:0] {
    GESTURE_NONE   = 2'd0,
    GESTURE_SINGLE = 2'd1,
    GESTURE_DOUBLE = 2'd2,
    GESTURE_LONG   = 2'd3
  } gesture_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_DOWN_LEVEL   = 2'd0,
    REG_LONG_PRESS_TICKS = 2'd1,
    REG_DOUBLE_CLICK     = 2'd2
  } cfg_reg_t;

  // One tick's result as it leaves the recognizer.
  typedef struct packed {
    gesture_t gesture;
    logic     key_pressed;
  } bcgd_result_t;

  // Recognizer status, visible to the top level for checking.
  typedef struct packed {
    logic waiting_long;
    logic waiting_double;
    logic timer_zero;
  } bcgd_status_t;

endpackage

`default_nettype wire

/* hdl/bcgd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one raw pin sample per item.
interface bcgd_in_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

// Result channel: one gesture report per item.
interface bcgd_out_if
  import bcgd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [GESTURE_W-1:0] gesture;
  logic                 key_pressed;

  modport source (output valid, output gesture, output key_pressed, input ready);
  modport sink   (input valid, input gesture, input key_pressed, output ready);
endinterface

// Configuration write channel.
interface bcgd_cfg_if
  import bcgd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/bcgd_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

// Register file. Durations are stored already clamped to the timer range
// (zero becomes one tick, too large becomes the timer maximum).
module bcgd_cfg
  import bcgd_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output logic                       key_down_level,
  output logic [TIMER_BITS-1:0]      long_dur,
  output logic [TIMER_BITS-1:0]      double_dur
);

  localparam int EXT_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
  localparam logic [EXT_W-1:0] TIMER_MAX = EXT_W'({TIMER_BITS{1'b1}});

  function automatic logic [TIMER_BITS-1:0] clamp_dur(input logic [CFG_DATA_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext > TIMER_MAX) begin
      ext = TIMER_MAX;
    end
    if (ext == '0) begin
      ext = EXT_W'(1);
    end
    return TIMER_BITS'(ext);
  endfunction

  logic                  key_down_level_r, key_down_level_nxt;
  logic [TIMER_BITS-1:0] long_dur_r, long_dur_nxt;
  logic [TIMER_BITS-1:0] double_dur_r, double_dur_nxt;

  always_comb begin
    key_down_level_nxt = key_down_level_r;
    long_dur_nxt       = long_dur_r;
    double_dur_nxt     = double_dur_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_KEY_DOWN_LEVEL:   key_down_level_nxt = wr_data[0];
        REG_LONG_PRESS_TICKS: long_dur_nxt       = clamp_dur(wr_data);
        REG_DOUBLE_CLICK:     double_dur_nxt     = clamp_dur(wr_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_down_level_r <= KEY_DOWN_LEVEL_RST;
      long_dur_r       <= clamp_dur(LONG_PRESS_RST);
      double_dur_r     <= clamp_dur(DOUBLE_CLICK_RST);
    end else begin
      key_down_level_r <= key_down_level_nxt;
      long_dur_r       <= long_dur_nxt;
      double_dur_r     <= double_dur_nxt;
    end
  end

  assign key_down_level = key_down_level_r;
  assign long_dur       = long_dur_r;
  assign double_dur     = double_dur_r;

endmodule

`default_nettype wire

/* hdl/bcgd_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Debounce and gesture recognizer. State advances on each accepted item;
// the result for that item is produced combinationally alongside.
module bcgd_core
  import bcgd_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  key_level,
  input  wire logic                  key_down_level,
  input  wire logic [TIMER_BITS-1:0] long_dur,
  input  wire logic [TIMER_BITS-1:0] double_dur,
  output bcgd_result_t               result,
  output bcgd_status_t               status
);

  logic                  pressed_r, pressed_nxt;
  logic                  loaded_r, loaded_nxt;
  logic [EDGE_CNT_W-1:0] edge_cnt_r, edge_cnt_nxt;
  logic                  wait_long_r, wait_long_nxt;
  logic                  wait_double_r, wait_double_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;

  logic                  level_down;
  logic [EDGE_CNT_W-1:0] edge_cnt_inc;
  logic [TIMER_BITS-1:0] timer_dec;
  gesture_t              gesture;

  assign level_down   = (key_level == key_down_level);
  assign edge_cnt_inc = (edge_cnt_r < EDGE_SPACED) ? edge_cnt_r + 1'b1 : edge_cnt_r;
  assign timer_dec    = (timer_r != '0) ? timer_r - 1'b1 : timer_r;

  always_comb begin
    pressed_nxt     = pressed_r;
    loaded_nxt      = loaded_r;
    edge_cnt_nxt    = edge_cnt_r;
    wait_long_nxt   = wait_long_r;
    wait_double_nxt = wait_double_r;
    timer_nxt       = timer_r;
    gesture         = GESTURE_NONE;

    if (!loaded_r) begin
      loaded_nxt  = 1'b1;
      pressed_nxt = level_down;
    end else if ((level_down != pressed_r) && (edge_cnt_inc == EDGE_SPACED)) begin
      // Accepted edge: drives the recognizer, timer does not count this tick.
      pressed_nxt  = level_down;
      edge_cnt_nxt = '0;
      if (level_down) begin
        if (wait_double_r) begin
          wait_double_nxt = 1'b0;
          wait_long_nxt   = 1'b0;
          timer_nxt       = '0;
          gesture         = GESTURE_DOUBLE;
        end else begin
          wait_long_nxt = 1'b1;
          timer_nxt     = long_dur;
        end
      end else if (wait_long_r) begin
        wait_long_nxt   = 1'b0;
        wait_double_nxt = 1'b1;
        timer_nxt       = double_dur;
      end else if (wait_double_r) begin
        timer_nxt = double_dur;
      end
    end else begin
      // Steady level or a glitch edge: status follows, timer keeps running.
      if (level_down != pressed_r) begin
        pressed_nxt  = level_down;
        edge_cnt_nxt = '0;
      end else begin
        edge_cnt_nxt = edge_cnt_inc;
      end
      if (wait_long_r || wait_double_r) begin
        timer_nxt = timer_dec;
        if (timer_dec == '0) begin
          gesture         = wait_double_r ? GESTURE_SINGLE : GESTURE_LONG;
          wait_long_nxt   = 1'b0;
          wait_double_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r     <= 1'b0;
      loaded_r      <= 1'b0;
      edge_cnt_r    <= EDGE_SPACED;
      wait_long_r   <= 1'b0;
      wait_double_r <= 1'b0;
      timer_r       <= '0;
    end else if (step) begin
      pressed_r     <= pressed_nxt;
      loaded_r      <= loaded_nxt;
      edge_cnt_r    <= edge_cnt_nxt;
      wait_long_r   <= wait_long_nxt;
      wait_double_r <= wait_double_nxt;
      timer_r       <= timer_nxt;
    end
  end

  assign result.gesture     = gesture;
  assign result.key_pressed = pressed_nxt;

  assign status.waiting_long   = wait_long_r;
  assign status.waiting_double = wait_double_r;
  assign status.timer_zero     = (timer_r == '0);

endmodule

`default_nettype wire

/* hdl/button_click_gesture_detector.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Port     Payload                          Item
// --------  ---  -------  -------------------------------  --------------------------
// input     in   in_bus   key_level                        one raw pin sample (tick)
// result    out  out_bus  gesture[1:0], key_pressed        one report per tick
// config    in   cfg_bus  reg_index[1:0], data[15:0]       one register write
//
// One item is accepted per clock cycle while in_bus.ready is high. Its
// result is held in the output register and is offered on the cycle after
// acceptance; the recognizer state and that register both update at the
// accepting edge. in_bus.ready is high whenever the output register is
// empty or is being taken in the same cycle, so the input waits exactly as
// long as a held result is stalled. cfg_bus.ready is high whenever rst_n is
// high. Both ready signals are low during reset. Reset is synchronous on
// rst_n and returns the recognizer, the configuration registers and the
// output valid flag to their reset values.
module button_click_gesture_detector
  import bcgd_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bcgd_in_if.sink    in_bus,
  bcgd_out_if.source out_bus,
  bcgd_cfg_if.sink   cfg_bus
);

  logic                  key_down_level;
  logic [TIMER_BITS-1:0] long_dur;
  logic [TIMER_BITS-1:0] double_dur;

  logic         in_accept;
  bcgd_result_t result;
  bcgd_status_t status;

  // Output register.
  logic         out_valid_r, out_valid_nxt;
  bcgd_result_t out_data_r, out_data_nxt;

  // Configuration writes are taken whenever the block is out of reset; they
  // must only arrive while idle, which the block itself does not enforce.
  assign cfg_bus.ready = rst_n;

  bcgd_cfg #(
    .TIMER_BITS(TIMER_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (cfg_bus.valid && cfg_bus.ready),
    .wr_index      (cfg_bus.reg_index),
    .wr_data       (cfg_bus.data),
    .key_down_level(key_down_level),
    .long_dur      (long_dur),
    .double_dur    (double_dur)
  );

  // A new item may enter when the output register is empty or frees up this cycle.
  assign in_bus.ready = rst_n && (!out_valid_r || out_bus.ready);
  assign in_accept    = in_bus.valid && in_bus.ready;

  bcgd_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_accept),
    .key_level     (in_bus.key_level),
    .key_down_level(key_down_level),
    .long_dur      (long_dur),
    .double_dur    (double_dur),
    .result        (result),
    .status        (status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.gesture     = out_data_r.gesture;
  assign out_bus.key_pressed = out_data_r.key_pressed;

  // The two waits are exclusive.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({status.waiting_long, status.waiting_double}))
    else $error("long-press and double-click waits armed together");

  // An armed wait always has time left on the countdown.
  assert property (@(posedge clk) disable iff (!rst_n)
    (status.waiting_long || status.waiting_double) |-> !status.timer_zero)
    else $error("wait armed with an expired timer");

  // Every accepted item leaves a result in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r && (out_data_r == $past(result)))
    else $error("accepted item did not reach the output register");

  // A double click can only be reported while a double-click wait is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (result.gesture == GESTURE_DOUBLE)) |-> status.waiting_double)
    else $error("double click reported without a pending wait");

endmodule

`default_nettype wire

/* bench/button_click_gesture_detector_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the button gesture detector. Raw pin samples go in
// one item per tick, and every report that comes out is compared with a
// cycle-free software copy of the recognizer that runs on the same samples.
module button_click_gesture_detector_test;
  import bcgd_pkg::*;

  localparam int TIMER_BITS = 16;
  localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 1;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_PHASES = 7;
  localparam int TICKS_PER_PHASE = 75;

  // A register index that has no register behind it. Writes to it must be
  // ignored by the block.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  bcgd_in_if  in_ch ();
  bcgd_out_if out_ch ();
  bcgd_cfg_if cfg_ch ();

  button_click_gesture_detector #(
    .TIMER_BITS(TIMER_BITS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch),
    .cfg_bus(cfg_ch)
  );

  // Largest idle gap each side may draw per item. Zero gives stretches in
  // which items move on every cycle.
  int in_gap_max = 0;
  int out_stall_max = 0;

  int failures = 0;
  int ticks_sent = 0;
  int reports_checked = 0;
  int register_writes = 0;
  int gesture_tally [4] = '{0, 0, 0, 0};

  // Reports the recognizer copy has produced and the block has not yet sent.
  bcgd_result_t expected_reports [$];

  // Mirror of the configuration registers.
  logic                  key_down_cfg;
  logic [CFG_DATA_W-1:0] long_press_cfg;
  logic [CFG_DATA_W-1:0] double_click_cfg;

  // Mirror of the recognizer state.
  logic                  pressed_now;
  logic                  status_loaded;
  logic [EDGE_CNT_W-1:0] edge_spacing;
  logic                  long_pending;
  logic                  double_pending;
  logic [TIMER_BITS-1:0] countdown;

  // A register value of zero still means one tick, and a value wider than
  // the countdown clamps to its largest count.
  function automatic logic [TIMER_BITS-1:0] ticks_to_count(input logic [CFG_DATA_W-1:0] r);
    longint unsigned d;
    d = r;
    if (d > TIMER_MAX) d = TIMER_MAX;
    if (d == 0) d = 1;
    return d[TIMER_BITS-1:0];
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Advances the recognizer copy by one tick and queues the report it makes.
  task automatic predict_report(input logic key_level);
    logic         down;
    logic         spaced;
    gesture_t     g;
    bcgd_result_t r;
    down = (key_level == key_down_cfg);
    g = GESTURE_NONE;
    if (!status_loaded) begin
      // The very first tick only loads the status; it is not an edge.
      status_loaded = 1'b1;
      pressed_now = down;
    end else begin
      if (edge_spacing < EDGE_SPACED) edge_spacing = edge_spacing + 1'b1;
      spaced = edge_spacing >= EDGE_SPACED;
      if (down != pressed_now && spaced) begin
        // An accepted edge wins over an expiry on the same tick.
        pressed_now = down;
        edge_spacing = '0;
        if (down) begin
          if (double_pending) begin
            double_pending = 1'b0;
            long_pending = 1'b0;
            countdown = '0;
            g = GESTURE_DOUBLE;
          end else begin
            long_pending = 1'b1;
            countdown = ticks_to_count(long_press_cfg);
          end
        end else if (long_pending) begin
          long_pending = 1'b0;
          double_pending = 1'b1;
          countdown = ticks_to_count(double_click_cfg);
        end else if (double_pending) begin
          countdown = ticks_to_count(double_click_cfg);
        end
      end else begin
        // A glitch still moves the status and restarts the spacing count,
        // but the countdown keeps running as if nothing happened.
        if (down != pressed_now) begin
          pressed_now = down;
          edge_spacing = '0;
        end
        if (long_pending || double_pending) begin
          if (countdown != 0) countdown = countdown - 1'b1;
          if (countdown == 0) begin
            g = double_pending ? GESTURE_SINGLE : GESTURE_LONG;
            long_pending = 1'b0;
            double_pending = 1'b0;
          end
        end
      end
    end
    r.gesture = g;
    r.key_pressed = pressed_now;
    expected_reports.push_back(r);
  endtask

  // Offers one pin sample after a random gap and waits until it is taken.
  // Valid stays high on return so that a back-to-back item keeps it high.
  task automatic send_tick(input logic level);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.key_level <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.key_level <= level;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_report(level);
    ticks_sent++;
  endtask

  // Holds the key down or up for a number of ticks, in terms of the
  // configured pressed level.
  task automatic hold_key(input logic down, input int ticks);
    repeat (ticks) send_tick(down ? key_down_cfg : ~key_down_cfg);
  endtask

  // Stops the input and waits until every report has come back. Each item
  // makes exactly one report, so the wait ends once no prediction is left.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_KEY_DOWN_LEVEL:   key_down_cfg = value[0];
      REG_LONG_PRESS_TICKS: long_press_cfg = value;
      REG_DOUBLE_CLICK:     double_click_cfg = value;
      default: ;
    endcase
    register_writes++;
    @(posedge clk);
  endtask

  function automatic int idle_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 19;
    endcase
  endfunction

  // Under the reset settings the pin at level zero means pressed. The first
  // sample must only load the status, and a release with nothing armed must
  // stay silent. The key then rests up long enough for the next press to
  // count as a real edge.
  task automatic test_first_tick();
    in_gap_max = 0;
    out_stall_max = 19;
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Short timers so that each gesture takes a handful of ticks.
  task automatic test_click_gestures();
    settle();
    in_gap_max = 19;
    out_stall_max = 19;
    write_register(REG_KEY_DOWN_LEVEL, 16'd1);
    write_register(REG_LONG_PRESS_TICKS, 16'd4);
    write_register(REG_DOUBLE_CLICK, 16'd3);
    // The release lands on the tick where the long press would expire; the
    // edge wins and the double-click window then runs out as a single click.
    hold_key(1'b1, 4);
    hold_key(1'b0, 4);
    // Press, release, press inside the window: a double click.
    hold_key(1'b1, 2);
    hold_key(1'b0, 2);
    hold_key(1'b1, 2);
    hold_key(1'b0, 2);
    // Held one tick past the long-press time.
    hold_key(1'b1, 5);
    hold_key(1'b0, 2);
    // A release right after a press is a glitch; the long press goes on.
    hold_key(1'b1, 1);
    hold_key(1'b0, 2);
  endtask

  // Zero durations count as one tick; the largest durations must keep both
  // waits open across a long hold and a short gap. Idling is off here.
  task automatic test_timer_limits();
    settle();
    in_gap_max = 0;
    out_stall_max = 0;
    write_register(REG_LONG_PRESS_TICKS, 16'd0);
    write_register(REG_DOUBLE_CLICK, 16'd0);
    hold_key(1'b0, 3);
    hold_key(1'b1, 2);
    hold_key(1'b0, 2);
    hold_key(1'b1, 2);
    hold_key(1'b0, 3);
    settle();
    write_register(REG_SPARE, 16'($urandom_range(0, 65535)));
    write_register(REG_KEY_DOWN_LEVEL, 16'd0);
    write_register(REG_LONG_PRESS_TICKS, 16'hFFFF);
    write_register(REG_DOUBLE_CLICK, 16'hFFFF);
    hold_key(1'b0, 2);
    hold_key(1'b1, 100);
    hold_key(1'b0, 2);
    hold_key(1'b1, 2);
    hold_key(1'b0, 2);
    hold_key(1'b1, 2);
    hold_key(1'b0, 2);
  endtask

  // Each phase picks new settings and idling, then plays alternating holds
  // whose lengths straddle the configured timers. Some holds last a single
  // tick to make glitches, and some stretches are plain random pin noise.
  task automatic test_random_gestures();
    int phase_end;
    int pick;
    int n;
    logic down;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      in_gap_max = idle_limit();
      out_stall_max = idle_limit();
      case (phase)
        0: begin
          write_register(REG_KEY_DOWN_LEVEL, 16'd0);
          write_register(REG_LONG_PRESS_TICKS, 16'd1);
          write_register(REG_DOUBLE_CLICK, 16'd1);
        end
        1: begin
          write_register(REG_KEY_DOWN_LEVEL, 16'd1);
          write_register(REG_LONG_PRESS_TICKS, 16'($urandom_range(0, 3)));
          write_register(REG_DOUBLE_CLICK, 16'($urandom_range(0, 3)));
        end
        default: begin
          write_register(REG_KEY_DOWN_LEVEL, 16'($urandom_range(0, 1)));
          write_register(REG_LONG_PRESS_TICKS, 16'($urandom_range(1, 24)));
          write_register(REG_DOUBLE_CLICK, 16'($urandom_range(1, 12)));
        end
      endcase
      phase_end = ticks_sent + TICKS_PER_PHASE;
      while (ticks_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          n = $urandom_range(1, 6);
          repeat (n) send_tick(1'($urandom_range(0, 1)));
        end else begin
          down = !pressed_now;
          if (pick < 25) n = 1;
          else if (down) n = $urandom_range(2, int'(long_press_cfg) + 3);
          else n = $urandom_range(2, int'(double_click_cfg) + 3);
          hold_key(down, n);
        end
      end
    end
  endtask

  // Takes reports after a random stall and checks each one against the
  // oldest prediction.
  initial begin : report_sink
    int stall;
    bcgd_result_t want;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_ch.valid === 1'b1));
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("report with nothing expected: gesture %0d, pressed %0b",
                               out_ch.gesture, out_ch.key_pressed));
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        gesture_tally[want.gesture]++;
        if (out_ch.gesture !== want.gesture)
          note_failure($sformatf("report %0d gesture: expected %s, got %0d",
                                 reports_checked, want.gesture.name(), out_ch.gesture));
        if (out_ch.key_pressed !== want.key_pressed)
          note_failure($sformatf("report %0d key_pressed: expected %0b, got %0b",
                                 reports_checked, want.key_pressed, out_ch.key_pressed));
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.key_level <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= REG_KEY_DOWN_LEVEL;
    cfg_ch.data <= '0;

    key_down_cfg = KEY_DOWN_LEVEL_RST;
    long_press_cfg = LONG_PRESS_RST;
    double_click_cfg = DOUBLE_CLICK_RST;
    pressed_now = 1'b0;
    status_loaded = 1'b0;
    edge_spacing = EDGE_SPACED;
    long_pending = 1'b0;
    double_pending = 1'b0;
    countdown = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_first_tick();
    test_click_gestures();
    test_timer_limits();
    test_random_gestures();
    settle();
    if (expected_reports.size() != 0)
      note_failure($sformatf("%0d reports never arrived", expected_reports.size()));

    $display("Drove %0d pin samples across %0d register writes and checked %0d reports.",
             ticks_sent, register_writes, reports_checked);
    $display("Gestures: %0d none, %0d single, %0d double, %0d long; %0d failures.",
             gesture_tally[GESTURE_NONE], gesture_tally[GESTURE_SINGLE],
             gesture_tally[GESTURE_DOUBLE], gesture_tally[GESTURE_LONG], failures);
    if (failures == 0) begin
      $display("** button_click_gesture_detector: PASSED **");
    end else begin
      $display("** button_click_gesture_detector: FAILED **");
    end
    $finish;
  end

  // Far beyond the slowest correct run, in which both sides draw their
  // largest idle gap on every item of the random phases.
  initial begin
    #20ms;
    $display("Timed out with %0d reports still outstanding.", expected_reports.size());
    $display("** button_click_gesture_detector: FAILED **");
    $finish;
  end

endmodule
